// ----- hw/rtl/rarx_pkg.sv -----
// ----------------------------------------------------------------------------
// rarx_pkg
// shared types and constants of the radio api frame receiver
// ----------------------------------------------------------------------------
package rarx_pkg;

    localparam int unsigned BYTE_W       = 8;
    localparam int unsigned WORD_W       = 16;
    localparam logic [WORD_W-1:0] HEADER_BYTES = 16'd5;
    localparam logic [BYTE_W-1:0] DELIM_RESET  = 8'd126;

    // result kinds
    localparam logic KIND_PAYLOAD   = 1'b0;
    localparam logic KIND_FRAME_END = 1'b1;

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_LENGTH,
        PH_API,
        PH_SOURCE,
        PH_RSSI,
        PH_OPTIONS,
        PH_PAYLOAD,
        PH_CHECKSUM
    } rarx_phase_t;

    typedef struct packed {
        logic              result_kind;
        logic [BYTE_W-1:0] data_byte;
        logic [WORD_W-1:0] payload_index;
        logic [BYTE_W-1:0] api_id;
        logic [WORD_W-1:0] source_addr;
        logic [BYTE_W-1:0] signal_strength;
        logic [WORD_W-1:0] payload_count;
    } rarx_result_t;

endpackage

// ----- hw/rtl/rarx_parser.sv -----
// ----------------------------------------------------------------------------
// rarx_parser
// frame state machine: header capture and per-byte result generation
// ----------------------------------------------------------------------------
module rarx_parser
    import rarx_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_write,
    input  logic [BYTE_W-1:0] cfg_data,
    input  logic              byte_fire,
    input  logic [BYTE_W-1:0] byte_in,
    output logic              res_valid,
    output rarx_result_t      res
);

    rarx_phase_t       phase_reg, phase_next;
    logic [BYTE_W-1:0] delim_reg;
    logic [WORD_W-1:0] count_reg, count_next;
    logic [WORD_W-1:0] length_reg, length_next;
    logic [WORD_W-1:0] expect_reg, expect_next;
    logic [BYTE_W-1:0] api_reg, api_next;
    logic [WORD_W-1:0] source_reg, source_next;
    logic [BYTE_W-1:0] rssi_reg, rssi_next;
    logic [WORD_W:0]   count_inc;

    assign count_inc = {1'b0, count_reg} + {{WORD_W{1'b0}}, 1'b1};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            delim_reg <= DELIM_RESET;
        end
        else if (cfg_write)
        begin
            delim_reg <= cfg_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_IDLE;
            count_reg  <= '0;
            length_reg <= '0;
            expect_reg <= '0;
            api_reg    <= '0;
            source_reg <= '0;
            rssi_reg   <= '0;
        end
        else if (byte_fire)
        begin
            phase_reg  <= phase_next;
            count_reg  <= count_next;
            length_reg <= length_next;
            expect_reg <= expect_next;
            api_reg    <= api_next;
            source_reg <= source_next;
            rssi_reg   <= rssi_next;
        end
    end

    always_comb
    begin
        phase_next  = phase_reg;
        count_next  = count_reg;
        length_next = length_reg;
        expect_next = expect_reg;
        api_next    = api_reg;
        source_next = source_reg;
        rssi_next   = rssi_reg;
        res_valid   = 1'b0;

        res.result_kind     = KIND_PAYLOAD;
        res.data_byte       = byte_in;
        res.payload_index   = count_reg;
        res.api_id          = api_reg;
        res.source_addr     = source_reg;
        res.signal_strength = rssi_reg;
        res.payload_count   = expect_reg;

        unique case (phase_reg)
            PH_IDLE:
            begin
                if (byte_in == delim_reg)
                begin
                    phase_next  = PH_LENGTH;
                    count_next  = '0;
                    length_next = '0;
                end
            end
            PH_LENGTH:
            begin
                length_next = {length_reg[WORD_W-BYTE_W-1:0], byte_in};
                count_next  = count_inc[WORD_W-1:0];
                if (count_reg != '0)
                begin
                    count_next = '0;
                    phase_next = PH_API;
                end
            end
            PH_API:
            begin
                api_next    = byte_in;
                source_next = '0;
                count_next  = '0;
                phase_next  = PH_SOURCE;
            end
            PH_SOURCE:
            begin
                source_next = {source_reg[WORD_W-BYTE_W-1:0], byte_in};
                count_next  = count_inc[WORD_W-1:0];
                if (count_reg != '0)
                begin
                    count_next = '0;
                    phase_next = PH_RSSI;
                end
            end
            PH_RSSI:
            begin
                rssi_next  = byte_in;
                phase_next = PH_OPTIONS;
            end
            PH_OPTIONS:
            begin
                // payload length clamps at zero for short frames
                expect_next = (length_reg > HEADER_BYTES) ? (length_reg - HEADER_BYTES) : '0;
                count_next  = '0;
                phase_next  = (length_reg > HEADER_BYTES) ? PH_PAYLOAD : PH_CHECKSUM;
            end
            PH_PAYLOAD:
            begin
                res_valid  = 1'b1;
                count_next = count_inc[WORD_W-1:0];
                if (count_inc >= {1'b0, expect_reg})
                begin
                    count_next = '0;
                    phase_next = PH_CHECKSUM;
                end
            end
            PH_CHECKSUM:
            begin
                res_valid         = 1'b1;
                res.result_kind   = KIND_FRAME_END;
                res.payload_index = '0;
                count_next        = '0;
                phase_next        = PH_IDLE;
            end
            default:
            begin
                phase_next = PH_IDLE;
            end
        endcase
    end

    a_checksum_returns_idle: assert property (@(posedge clk) disable iff (!rst_n)
        byte_fire && phase_reg == PH_CHECKSUM |=> phase_reg == PH_IDLE)
        else $error("parser did not return to idle after checksum");

    a_index_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res.result_kind == KIND_PAYLOAD |-> res.payload_index < res.payload_count)
        else $error("payload index beyond payload count");

    a_payload_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_PAYLOAD |-> expect_reg != '0)
        else $error("payload phase with empty payload");

endmodule

// ----- hw/rtl/rarx_out_stage.sv -----
// ----------------------------------------------------------------------------
// rarx_out_stage
// result register with skid entry so the input side is stalled from a flop
// ----------------------------------------------------------------------------
module rarx_out_stage
    import rarx_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         push,
    input  rarx_result_t push_data,
    output logic         full,
    output logic         out_valid,
    input  logic         out_stall,
    output rarx_result_t out_data
);

    logic         main_valid_reg, main_valid_next;
    logic         skid_valid_reg, skid_valid_next;
    rarx_result_t main_reg, main_next;
    rarx_result_t skid_reg, skid_next;
    logic         pop;

    assign pop       = main_valid_reg && !out_stall;
    assign full      = skid_valid_reg;
    assign out_valid = main_valid_reg;
    assign out_data  = main_reg;

    always_comb
    begin
        main_valid_next = main_valid_reg;
        skid_valid_next = skid_valid_reg;
        main_next       = main_reg;
        skid_next       = skid_reg;
        if (skid_valid_reg)
        begin
            if (pop)
            begin
                main_next       = skid_reg;
                skid_valid_next = 1'b0;
            end
        end
        else if (push)
        begin
            if (!main_valid_reg || pop)
            begin
                main_next       = push_data;
                main_valid_next = 1'b1;
            end
            else
            begin
                skid_next       = push_data;
                skid_valid_next = 1'b1;
            end
        end
        else if (pop)
        begin
            main_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            main_valid_reg <= main_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        main_reg <= main_next;
        skid_reg <= skid_next;
    end

    a_skid_behind_main: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> main_valid_reg)
        else $error("skid entry held without a main entry");

    a_no_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> !push)
        else $error("result pushed into a full output stage");

    a_skid_drains: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg && pop |=> main_valid_reg && !skid_valid_reg)
        else $error("skid entry not moved into main register");

endmodule

// ----- hw/rtl/radio_api_frame_receiver.sv -----
// ----------------------------------------------------------------------------
// radio_api_frame_receiver
// byte-wise parser for rx16-style api frames from a serial radio link
// ----------------------------------------------------------------------------
//
//  channel   direction  handshake              transfer content
//  -------   ---------  ---------------------  ------------------------------
//  in        sink       in_valid / in_stall    raw_byte
//  out       source     out_valid / out_stall  result_kind .. payload_count
//  cfg       sink       cfg_valid / cfg_ready  start_delimiter
//
//  one byte per cycle while in_stall is low; the frame state updates in the
//  cycle a byte transfers and its result is registered in the output stage on the following edge
//  in_stall comes straight from the skid flop, so it rises only after two
//  results are parked behind a stalled output
//  reset (rst_n low, async) returns to idle hunting for delimiter 126
//  cfg_ready is always high; the user must rewrite the delimiter only between frames, the block does not enforce it
//
module radio_api_frame_receiver
    import rarx_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,

    // configuration
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [BYTE_W-1:0]   start_delimiter,

    // byte input
    input  logic                in_valid,
    output logic                in_stall,
    input  logic [BYTE_W-1:0]   raw_byte,

    // result output
    output logic                out_valid,
    input  logic                out_stall,
    output logic                result_kind,
    output logic [BYTE_W-1:0]   data_byte,
    output logic [WORD_W-1:0]   payload_index,
    output logic [BYTE_W-1:0]   api_id,
    output logic [WORD_W-1:0]   source_addr,
    output logic [BYTE_W-1:0]   signal_strength,
    output logic [WORD_W-1:0]   payload_count
);

    logic         byte_fire;
    logic         res_valid;
    logic         stage_full;
    rarx_result_t res;
    rarx_result_t out_data;

    // register write always accepted
    assign cfg_ready = 1'b1;

    // a byte transfers whenever the skid entry is free
    assign in_stall  = stage_full;
    assign byte_fire = in_valid && !stage_full;

    rarx_parser u_parser (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_valid && cfg_ready),
        .cfg_data  (start_delimiter),
        .byte_fire (byte_fire),
        .byte_in   (raw_byte),
        .res_valid (res_valid),
        .res       (res)
    );

    // only payload and checksum bytes produce a result
    rarx_out_stage u_out_stage (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (byte_fire && res_valid),
        .push_data (res),
        .full      (stage_full),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

    // unpack result fields onto separate ports
    assign result_kind     = out_data.result_kind;
    assign data_byte       = out_data.data_byte;
    assign payload_index   = out_data.payload_index;
    assign api_id          = out_data.api_id;
    assign source_addr     = out_data.source_addr;
    assign signal_strength = out_data.signal_strength;
    assign payload_count   = out_data.payload_count;

endmodule
